[rtl/tws_pkg.sv]
// Types, constants and scan functions for the text word splitter.
// Used by tws_obuf and text_word_splitter_top; no dependencies.

package tws_pkg;

   localparam int MAX_WORD = 256;
   localparam int WL_W     = $clog2(MAX_WORD + 1);
   localparam int MAX_RES  = 3;

   localparam logic [7:0] CH_HYPHEN  = 8'h2D;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_APOS    = 8'h27;

   typedef enum logic [1:0] {
      KIND_CHAR  = 2'd0,
      KIND_END   = 2'd1,
      KIND_PUNCT = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      CSR_NUMBER_WORDS     = 3'd0,
      CSR_SHOW_PUNCTUATION = 3'd1,
      CSR_IGNORE_FILE      = 3'd2,
      CSR_ONLY_MODE        = 3'd3,
      CSR_ONLY_FILE        = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic number_words;
      logic show_punctuation;
      logic ignore_file;
      logic only_mode;
      logic only_file;
   } cfg_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  glyph;
      logic [31:0] word_number;
   } result_type;

   // results caused by one input item, slot 0 goes out first
   typedef struct packed {
      logic [1:0]                 n;
      result_type [MAX_RES-1:0]   res;
   } bundle_type;

   typedef struct packed {
      logic [WL_W-1:0] wl;
      logic            ap;
      logic            hy;
      logic [31:0]     cnt;
      bundle_type      bun;
   } scan_type;

   function automatic logic is_letter(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_punct(logic [7:0] c);
      return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
             (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
   endfunction

   function automatic logic visible(cfg_type cfg);
      return !cfg.ignore_file && (!cfg.only_mode || cfg.only_file);
   endfunction

   // saturating word number
   function automatic logic [31:0] sat_next(logic [31:0] cnt);
      return (cnt == 32'hFFFF_FFFF) ? cnt : cnt + 32'd1;
   endfunction

   function automatic scan_type emit(scan_type s, kind_type k, logic [7:0] g,
                                     logic [31:0] num, cfg_type cfg);
      scan_type r;
      r = s;
      if (r.bun.n != 2'd3) begin
         r.bun.res[r.bun.n].kind        = k;
         r.bun.res[r.bun.n].glyph       = g;
         r.bun.res[r.bun.n].word_number = cfg.number_words ? num : 32'd0;
         r.bun.n = r.bun.n + 2'd1;
      end
      return r;
   endfunction

   function automatic scan_type close_word(scan_type s, cfg_type cfg);
      scan_type r;
      r = s;
      if (r.wl != '0) begin
         r.cnt = sat_next(r.cnt);
         if (visible(cfg)) begin
            r = emit(r, KIND_END, 8'h00, r.cnt, cfg);
         end
      end
      r.wl = '0;
      r.ap = 1'b0;
      return r;
   endfunction

   function automatic scan_type delimiter(scan_type s, logic [7:0] c, cfg_type cfg);
      scan_type r;
      r = close_word(s, cfg);
      if (cfg.show_punctuation && is_punct(c)) begin
         r = emit(r, KIND_PUNCT, c, r.cnt, cfg);
      end
      return r;
   endfunction

   function automatic scan_type handle(scan_type s, logic [7:0] c, cfg_type cfg);
      scan_type r;
      logic     take;
      r    = s;
      take = is_letter(c) || (c == CH_APOS && r.wl != '0 && !r.ap);
      if (c == CH_HYPHEN) begin
         r.hy = 1'b1;
      end else if (!take) begin
         r = delimiter(r, c, cfg);
      end else begin
         if (c == CH_APOS) begin
            r.ap = 1'b1;
         end
         r.wl = r.wl + WL_W'(1);
         if (visible(cfg)) begin
            r = emit(r, KIND_CHAR, c, sat_next(r.cnt), cfg);
         end
         // cut the word at its maximum length
         if (r.wl >= WL_W'(MAX_WORD)) begin
            r = close_word(r, cfg);
         end
      end
      return r;
   endfunction

endpackage

[rtl/tws_obuf.sv]
// Result buffer: holds the results caused by one input item and sends them out
// one per cycle while rsp_tready is high. Depends on tws_pkg.

module tws_obuf (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  tws_pkg::bundle_type load_bundle,
   output logic                free,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [39:0]         rsp_tdata,  // glyph[7:0], word_number[39:8]
   output logic [1:0]          rsp_tuser,  // kind[1:0]
   output logic                rsp_tlast
);
   import tws_pkg::*;

   bundle_type bun_ff;
   logic       valid_ff;
   logic       valid_in;
   logic [1:0] idx_ff;
   logic [1:0] idx_in;
   logic       at_last;
   result_type cur;

   assign cur     = bun_ff.res[idx_ff];
   assign at_last = (idx_ff == bun_ff.n - 2'd1);

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {cur.word_number, cur.glyph};
   assign rsp_tuser  = cur.kind;
   assign rsp_tlast  = at_last;
   assign free       = !valid_ff || (rsp_tready && at_last);

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = 2'd0;
      end else if (valid_ff && rsp_tready) begin
         if (at_last) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bun_ff <= load_bundle;
      end
   end

endmodule

[rtl/text_word_splitter_top.sv]
// Text word splitter top level: scan logic, word state and register port.
// Depends on tws_pkg and tws_obuf.
// The first result of a character shows in the cycle after it is accepted.
// Throughput: one character per cycle while each causes at most one result and
// rsp_tready is high; a character with more results holds the buffer and input.
// Reset (synchronous, active high) clears registers, word state and buffer.

module text_word_splitter_top (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // character[7:0]
   input  logic        req_tlast,   // end_of_input
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // glyph[7:0], word_number[39:8]
   output logic [1:0]  rsp_tuser,   // kind[1:0]
   output logic        rsp_tlast,   // last
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import tws_pkg::*;

   cfg_type         cfg_ff;
   cfg_type         cfg_in;
   logic [WL_W-1:0] wl_ff;
   logic            ap_ff;
   logic            hy_ff;
   logic [31:0]     cnt_ff;
   scan_type        scan_in;
   logic            accept;
   logic            obuf_free;
   logic            csr_wr;
   csr_index_type   csr_idx;
   logic            rd_bit;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_index_type'(csr_paddr[4:2]);

   always_comb begin
      cfg_in = cfg_ff;
      rd_bit = 1'b0;
      case (csr_idx)
         CSR_NUMBER_WORDS: begin
            rd_bit = cfg_ff.number_words;
            if (csr_wr) cfg_in.number_words = csr_pwdata[0];
         end
         CSR_SHOW_PUNCTUATION: begin
            rd_bit = cfg_ff.show_punctuation;
            if (csr_wr) cfg_in.show_punctuation = csr_pwdata[0];
         end
         CSR_IGNORE_FILE: begin
            rd_bit = cfg_ff.ignore_file;
            if (csr_wr) cfg_in.ignore_file = csr_pwdata[0];
         end
         CSR_ONLY_MODE: begin
            rd_bit = cfg_ff.only_mode;
            if (csr_wr) cfg_in.only_mode = csr_pwdata[0];
         end
         CSR_ONLY_FILE: begin
            rd_bit = cfg_ff.only_file;
            if (csr_wr) cfg_in.only_file = csr_pwdata[0];
         end
         default: begin
            rd_bit = 1'b0;
         end
      endcase
   end

   assign csr_prdata = {31'd0, rd_bit};

   assign req_tready = obuf_free;
   assign accept     = req_tvalid && req_tready;

   // one input item through the scan, in the order the text defines
   always_comb begin
      scan_in.wl  = wl_ff;
      scan_in.ap  = ap_ff;
      scan_in.hy  = hy_ff;
      scan_in.cnt = cnt_ff;
      scan_in.bun = '0;
      if (req_tlast) begin
         if (hy_ff) begin
            scan_in = delimiter(scan_in, CH_HYPHEN, cfg_ff);
         end else begin
            scan_in = close_word(scan_in, cfg_ff);
         end
         scan_in.hy = 1'b0;
      end else if (hy_ff) begin
         scan_in.hy = 1'b0;
         // drop a hyphen and newline pair, the word goes on
         if (req_tdata != CH_NEWLINE) begin
            scan_in = delimiter(scan_in, CH_HYPHEN, cfg_ff);
            scan_in = handle(scan_in, req_tdata, cfg_ff);
         end
      end else begin
         scan_in = handle(scan_in, req_tdata, cfg_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
         wl_ff  <= '0;
         ap_ff  <= 1'b0;
         hy_ff  <= 1'b0;
         cnt_ff <= 32'd0;
      end else begin
         cfg_ff <= cfg_in;
         if (accept) begin
            wl_ff  <= scan_in.wl;
            ap_ff  <= scan_in.ap;
            hy_ff  <= scan_in.hy;
            cnt_ff <= scan_in.cnt;
         end
      end
   end

   tws_obuf u_obuf (
      .clock       (clock),
      .reset       (reset),
      .load        (accept && (scan_in.bun.n != 2'd0)),
      .load_bundle (scan_in.bun),
      .free        (obuf_free),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule
